// ===== hw/rtl/cbr_pkg.sv =====
// Shared types, codes and helpers of the cache block reclaimer.
package cbr_pkg;

    // Input action codes
    localparam logic [1:0] ACT_MARK_CACHED = 2'd0;
    localparam logic [1:0] ACT_MARK_RECENT = 2'd1;
    localparam logic [1:0] ACT_CLEAR_RECENT = 2'd2;
    localparam logic [1:0] ACT_CHECK = 2'd3;

    // Reclaim mode codes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_LRU = 2'd1;
    localparam logic [1:0] MODE_ANY = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_ENABLE = 2'd0;
    localparam logic [1:0] CFG_MAX_SIZE = 2'd1;
    localparam logic [1:0] CFG_HIGH_PCT = 2'd2;
    localparam logic [1:0] CFG_LOW_PCT = 2'd3;

    localparam logic [6:0] HIGH_PCT_RESET = 7'd95;
    localparam logic [6:0] LOW_PCT_RESET = 7'd80;

    // (units * 512 + 1) * 100 = units * 51200 + 100
    localparam int SCALE_MUL = 51200;
    localparam int SCALE_ADD = 100;
    localparam int SCALED_W = 56;

    typedef enum logic [1:0] {
        OP_MARK_CACHED = 2'd0,
        OP_MARK_RECENT = 2'd1,
        OP_CLEAR_RECENT = 2'd2,
        OP_CHECK = 2'd3
    } t_op;

    // Classified command passed from front to back
    typedef struct packed {
        t_op                  op;
        logic [9:0]           blk;
        logic [SCALED_W-1:0]  scaled;
    } t_cmd;

    // Lowest set bit of a 32-bit word
    function automatic logic [4:0] ffs32(input logic [31:0] v);
        logic [4:0] r;
        r = '0;
        for (int i = 31; i >= 0; i--) begin
            if (v[i]) begin
                r = 5'(i);
            end
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/cbr_if.sv =====
// Handshake channel interfaces of the cache block reclaimer.
interface cbr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [9:0]  block_index;
    logic [38:0] allocated_units;
    modport source (output valid, action, block_index, allocated_units, input ready);
    modport sink (input valid, action, block_index, allocated_units, output ready);
endinterface

interface cbr_out_if;
    logic       valid;
    logic       ready;
    logic       reclaim_valid;
    logic [9:0] reclaimed_block;
    logic [1:0] mode_after;
    logic       last;
    modport source (output valid, reclaim_valid, reclaimed_block, mode_after, last,
                    input ready);
    modport sink (input valid, reclaim_valid, reclaimed_block, mode_after, last,
                  output ready);
endinterface

interface cbr_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [47:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/cbr_front.sv =====
// Front end: accepts input transactions, classifies them and queues commands.
module cbr_front #(
    parameter int NUM_BLOCKS = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    cbr_in_if.sink         i_in,
    output logic           o_cmd_valid,
    output cbr_pkg::t_cmd  o_cmd,
    input  logic           i_cmd_pop
);
    localparam logic [20:0] NB21 = 21'(NUM_BLOCKS);

    cbr_pkg::t_cmd r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    cbr_pkg::t_cmd cls;
    logic          keep;
    logic          in_range;
    logic          push;
    logic          pop;

    // Classify the incoming transaction
    always_comb begin
        in_range = 21'(i_in.block_index) < NB21;
        keep = 1'b1;
        cls.blk = i_in.block_index;
        cls.scaled = cbr_pkg::SCALED_W'(i_in.allocated_units)
                     * cbr_pkg::SCALED_W'(cbr_pkg::SCALE_MUL)
                     + cbr_pkg::SCALED_W'(cbr_pkg::SCALE_ADD);
        case (i_in.action)
            cbr_pkg::ACT_MARK_CACHED: begin
                cls.op = cbr_pkg::OP_MARK_CACHED;
                keep = in_range;
            end
            cbr_pkg::ACT_MARK_RECENT: begin
                cls.op = cbr_pkg::OP_MARK_RECENT;
                keep = in_range;
            end
            cbr_pkg::ACT_CLEAR_RECENT: cls.op = cbr_pkg::OP_CLEAR_RECENT;
            default: cls.op = cbr_pkg::OP_CHECK;
        endcase
    end

    assign i_in.ready = (r_cnt != 2'd2);
    assign push = i_in.valid && i_in.ready && keep;
    assign pop = i_cmd_pop && (r_cnt != 2'd0);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd = r_q[r_rp];

    // Hold queue payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

    // Advance queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

// ===== hw/rtl/cbr_back.sv =====
// Back end: block maps, watermark decision, reclaim scan and result register.
module cbr_back #(
    parameter int NUM_BLOCKS = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    cbr_cfg_if.sink        i_cfg,
    input  logic           i_cmd_valid,
    input  cbr_pkg::t_cmd  i_cmd,
    output logic           o_cmd_pop,
    cbr_out_if.source      o_out
);
    localparam int ROWS = (NUM_BLOCKS + 31) / 32;
    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int PW = $clog2(NUM_BLOCKS);
    localparam int BW = RW + 5;
    localparam int CW = $clog2(ROWS + 1);
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
    localparam logic [CW-1:0] CNT_END = CW'(ROWS);
    localparam logic [PW-1:0] LAST_POS = PW'(NUM_BLOCKS - 1);

    typedef enum logic [9:0] {
        ST_INIT   = 10'b0000000001,
        ST_IDLE   = 10'b0000000010,
        ST_MK_RD  = 10'b0000000100,
        ST_MK_WR  = 10'b0000001000,
        ST_CLR    = 10'b0000010000,
        ST_DECIDE = 10'b0000100000,
        ST_SR_RD  = 10'b0001000000,
        ST_SR_EV  = 10'b0010000000,
        ST_EVICT  = 10'b0100000000,
        ST_EMIT   = 10'b1000000000
    } t_state;

    function automatic logic [PW-1:0] after_pos(input logic [PW-1:0] p);
        logic [PW:0] pp;
        pp = {1'b0, p} + 1'b1;
        return (pp >= (PW+1)'(NUM_BLOCKS)) ? '0 : pp[PW-1:0];
    endfunction

    function automatic logic [RW-1:0] row_of(input logic [PW-1:0] p);
        logic [BW-1:0] w;
        w = BW'(p);
        return w[BW-1:5];
    endfunction

    function automatic logic [4:0] off_of(input logic [PW-1:0] p);
        logic [BW-1:0] w;
        w = BW'(p);
        return w[4:0];
    endfunction

    function automatic logic [PW-1:0] pos_of(input logic [RW-1:0] row, input logic [4:0] b);
        logic [BW-1:0] w;
        w = {row, b};
        return PW'(w);
    endfunction

    function automatic logic [9:0] to_blk10(input logic [PW-1:0] p);
        logic [PW+9:0] w;
        w = (PW+10)'(p);
        return w[9:0];
    endfunction

    // Configuration and watermark products
    logic        r_enable;
    logic [47:0] r_max;
    logic [6:0]  r_high;
    logic [6:0]  r_low;
    logic [54:0] r_hi_prod;
    logic [54:0] r_lo_prod;

    // Block maps, one 32-bit row per address
    logic [31:0] cached_mem [ROWS];
    logic [31:0] recent_mem [ROWS];
    logic [31:0] r_crd;
    logic [31:0] r_rrd;

    t_state        r_state, n_state;
    logic [RW-1:0] r_row, n_row;
    logic [4:0]    r_off, n_off;
    logic [4:0]    r_bit, n_bit;
    logic [CW-1:0] r_cnt, n_cnt;
    cbr_pkg::t_cmd r_cmd, n_cmd;
    logic [1:0]    r_mode, n_mode;
    logic [PW-1:0] r_scan, n_scan;
    logic          r_attempt, n_attempt;
    logic          r_lru, n_lru;
    logic          r_ffound, n_ffound;
    logic [PW-1:0] r_first, n_first;
    logic          r_res_ok, n_res_ok;
    logic [PW-1:0] r_res_blk, n_res_blk;
    logic          r_res_last, n_res_last;
    logic          r_ov;
    logic          r_o_ok;
    logic [9:0]    r_o_blk;
    logic [1:0]    r_o_mode;
    logic          r_o_last;

    logic          c_we, rc_we, rd_en, push_out, go;
    logic [31:0]   c_wd, rc_wd, mask, cand_c, cand_n;
    logic [PW-1:0] sp, first_eff;
    logic [4:0]    ffs_c, ffs_n;

    // Capture configuration writes
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_max <= '0;
            r_high <= cbr_pkg::HIGH_PCT_RESET;
            r_low <= cbr_pkg::LOW_PCT_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                cbr_pkg::CFG_ENABLE:   r_enable <= i_cfg.data[0];
                cbr_pkg::CFG_MAX_SIZE: r_max <= i_cfg.data;
                cbr_pkg::CFG_HIGH_PCT: r_high <= i_cfg.data[6:0];
                cbr_pkg::CFG_LOW_PCT:  r_low <= i_cfg.data[6:0];
                default: ;
            endcase
        end
    end

    // Precompute watermark products times 100
    always_ff @(posedge i_clk) begin
        r_hi_prod <= 55'(r_max) * 55'(r_high);
        r_lo_prod <= 55'(r_max) * 55'(r_low);
    end

    // Access the map memories
    always_ff @(posedge i_clk) begin
        if (c_we) begin
            cached_mem[r_row] <= c_wd;
        end
        if (rc_we) begin
            recent_mem[r_row] <= rc_wd;
        end
        if (rd_en) begin
            r_crd <= cached_mem[r_row];
            r_rrd <= recent_mem[r_row];
        end
    end

    // Row scan candidates
    always_comb begin
        if (r_cnt == '0) begin
            mask = ~((32'd1 << r_off) - 32'd1);
        end else if (r_cnt == CNT_END) begin
            mask = (32'd1 << r_off) - 32'd1;
        end else begin
            mask = '1;
        end
        cand_c = r_crd & mask;
        cand_n = r_crd & ~r_rrd & mask;
        ffs_c = cbr_pkg::ffs32(cand_c);
        ffs_n = cbr_pkg::ffs32(cand_n);
        first_eff = r_ffound ? r_first : pos_of(r_row, ffs_c);
    end

    // Sequence the back end
    always_comb begin
        n_state = r_state;
        n_row = r_row;
        n_off = r_off;
        n_bit = r_bit;
        n_cnt = r_cnt;
        n_cmd = r_cmd;
        n_mode = r_mode;
        n_scan = r_scan;
        n_attempt = r_attempt;
        n_lru = r_lru;
        n_ffound = r_ffound;
        n_first = r_first;
        n_res_ok = r_res_ok;
        n_res_blk = r_res_blk;
        n_res_last = r_res_last;
        c_we = 1'b0;
        rc_we = 1'b0;
        c_wd = '0;
        rc_wd = '0;
        rd_en = 1'b0;
        o_cmd_pop = 1'b0;
        push_out = 1'b0;
        go = 1'b0;
        sp = after_pos(r_scan);
        case (r_state)
            ST_INIT: begin
                c_we = 1'b1;
                rc_we = 1'b1;
                if (r_row == LAST_ROW) begin
                    n_row = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd = i_cmd;
                    n_row = row_of(PW'(i_cmd.blk));
                    n_bit = off_of(PW'(i_cmd.blk));
                    case (i_cmd.op)
                        cbr_pkg::OP_MARK_CACHED,
                        cbr_pkg::OP_MARK_RECENT: n_state = ST_MK_RD;
                        cbr_pkg::OP_CLEAR_RECENT: begin
                            n_row = '0;
                            n_state = ST_CLR;
                        end
                        default: n_state = ST_DECIDE;
                    endcase
                end
            end
            ST_MK_RD: begin
                rd_en = 1'b1;
                n_state = ST_MK_WR;
            end
            ST_MK_WR: begin
                if (r_cmd.op == cbr_pkg::OP_MARK_CACHED) begin
                    c_we = 1'b1;
                    c_wd = r_crd | (32'd1 << r_bit);
                end else begin
                    rc_we = 1'b1;
                    rc_wd = r_rrd | (32'd1 << r_bit);
                end
                n_state = ST_IDLE;
            end
            ST_CLR: begin
                rc_we = 1'b1;
                if (r_row == LAST_ROW) begin
                    n_row = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end
            ST_DECIDE: begin
                if (r_enable) begin
                    if (r_mode != cbr_pkg::MODE_IDLE) begin
                        if (r_cmd.scaled > 56'(r_lo_prod)) begin
                            go = 1'b1;
                        end else begin
                            n_mode = cbr_pkg::MODE_IDLE;
                        end
                    end else if (r_cmd.scaled > 56'(r_hi_prod)) begin
                        n_mode = cbr_pkg::MODE_LRU;
                        go = 1'b1;
                    end
                end
                if (go) begin
                    n_attempt = 1'b0;
                    n_lru = (n_mode == cbr_pkg::MODE_LRU);
                    n_row = row_of(sp);
                    n_off = off_of(sp);
                    n_cnt = '0;
                    n_ffound = 1'b0;
                    n_state = ST_SR_RD;
                end else begin
                    n_res_ok = 1'b0;
                    n_res_blk = '0;
                    n_res_last = 1'b1;
                    n_state = ST_EMIT;
                end
            end
            ST_SR_RD: begin
                rd_en = 1'b1;
                n_state = ST_SR_EV;
            end
            ST_SR_EV: begin
                if (r_lru && cand_n != '0) begin
                    n_bit = ffs_n;
                    n_state = ST_EVICT;
                end else if (!r_lru && cand_c != '0) begin
                    n_bit = ffs_c;
                    n_state = ST_EVICT;
                end else begin
                    if (!r_ffound && cand_c != '0) begin
                        n_ffound = 1'b1;
                        n_first = pos_of(r_row, ffs_c);
                    end
                    if (r_cnt == CNT_END) begin
                        if (r_lru && (r_ffound || cand_c != '0)) begin
                            // all cached blocks recent: fall back to any block
                            n_mode = cbr_pkg::MODE_ANY;
                            n_scan = first_eff;
                            n_lru = 1'b0;
                            n_row = row_of(after_pos(first_eff));
                            n_off = off_of(after_pos(first_eff));
                            n_cnt = '0;
                            n_state = ST_SR_RD;
                        end else begin
                            if (r_lru) begin
                                n_mode = cbr_pkg::MODE_ANY;
                            end
                            n_scan = LAST_POS;
                            n_res_ok = 1'b0;
                            n_res_blk = '0;
                            n_res_last = r_attempt;
                            n_state = ST_EMIT;
                        end
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                        n_row = (r_row == LAST_ROW) ? '0 : r_row + 1'b1;
                        n_state = ST_SR_RD;
                    end
                end
            end
            ST_EVICT: begin
                c_we = 1'b1;
                c_wd = r_crd & ~(32'd1 << r_bit);
                n_scan = pos_of(r_row, r_bit);
                n_res_ok = 1'b1;
                n_res_blk = pos_of(r_row, r_bit);
                n_res_last = r_attempt;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!r_ov || o_out.ready) begin
                    push_out = 1'b1;
                    if (r_res_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_attempt = 1'b1;
                        n_lru = (r_mode == cbr_pkg::MODE_LRU);
                        n_row = row_of(sp);
                        n_off = off_of(sp);
                        n_cnt = '0;
                        n_ffound = 1'b0;
                        n_state = ST_SR_RD;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_row <= '0;
            r_mode <= cbr_pkg::MODE_IDLE;
            r_scan <= '0;
            r_cnt <= '0;
            r_attempt <= 1'b0;
            r_lru <= 1'b0;
            r_ffound <= 1'b0;
            r_res_last <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row <= n_row;
            r_mode <= n_mode;
            r_scan <= n_scan;
            r_cnt <= n_cnt;
            r_attempt <= n_attempt;
            r_lru <= n_lru;
            r_ffound <= n_ffound;
            r_res_last <= n_res_last;
        end
    end

    // Hold working payload
    always_ff @(posedge i_clk) begin
        r_off <= n_off;
        r_bit <= n_bit;
        r_cmd <= n_cmd;
        r_first <= n_first;
        r_res_ok <= n_res_ok;
        r_res_blk <= n_res_blk;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (push_out) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_out) begin
            r_o_ok <= r_res_ok;
            r_o_blk <= to_blk10(r_res_blk);
            r_o_mode <= r_mode;
            r_o_last <= r_res_last;
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.reclaim_valid = r_o_ok;
    assign o_out.reclaimed_block = r_o_blk;
    assign o_out.mode_after = r_o_mode;
    assign o_out.last = r_o_last;
endmodule

// ===== hw/rtl/cache_block_reclaimer.sv =====
// Top level of the cache block reclaimer.
// Mark, mark-accessed and clear-recent transactions produce no result; a check produces one
// result (not reclaiming) or two (one per reclaim attempt, last set on the second). The front
// end queues up to two commands so input keeps flowing while the back end works. A mark is a
// read-modify-write of one 32-block map row; a recent-map clear and the clearing pass after reset
// write one row a cycle, and no command is taken during the reset pass. Each reclaim attempt
// scans map rows circularly, each row by a registered memory read, then a priority pick, up to
// (NUM_BLOCKS+31)/32+1 rows, doubled when the not-recent scan falls back to reclaiming any block.
module cache_block_reclaimer #(
    parameter int NUM_BLOCKS = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cbr_in_if.sink     i_in,
    cbr_out_if.source  o_out,
    cbr_cfg_if.sink    i_cfg
);
    logic          cmd_valid;
    logic          cmd_pop;
    cbr_pkg::t_cmd cmd;

    cbr_front #(.NUM_BLOCKS(NUM_BLOCKS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    cbr_back #(.NUM_BLOCKS(NUM_BLOCKS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (i_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out       (o_out)
    );
endmodule
